// ===== src/rdq_pkg.sv =====
// Shared types and codes for the reversible deque.
package rdq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH    = 3'd0,
    REQ_REVERSE = 3'd1,
    REQ_DISCARD = 3'd2,
    REQ_TAKE    = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_e_t;

  typedef enum logic [0:0] {
    S_IDLE   = 1'b0,
    S_RESULT = 1'b1
  } state_t;

  typedef struct packed {
    logic   exec;
    req_e_t req;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic error;
  } dp_status_t;

endpackage

// ===== src/rdq_ctrl.sv =====
// Controller state machine: input and result handshakes and command issue.
module rdq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic [2:0]         in_req,
  input  logic               out_tready,
  input  rdq_pkg::dp_status_t status,
  output logic               in_tready,
  output logic               out_tvalid,
  output rdq_pkg::cmd_t      cmd
);

  rdq_pkg::state_t state_r;
  rdq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdq_pkg::S_IDLE: begin
        if (in_tvalid && rdq_pkg::req_e_t'(in_req) == rdq_pkg::REQ_TAKE) begin
          state_nxt = rdq_pkg::S_RESULT;
        end
      end
      rdq_pkg::S_RESULT: begin
        if (out_tready) begin
          state_nxt = rdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = rdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd.exec   = 1'b0;
    cmd.req    = rdq_pkg::req_e_t'(in_req);
    unique case (state_r)
      rdq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.exec  = in_tvalid;
      end
      rdq_pkg::S_RESULT: begin
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && cmd.req == rdq_pkg::REQ_TAKE |=> out_tvalid)
    else $error("take did not raise a result");

  a_discard_empty_sets_error: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && cmd.req == rdq_pkg::REQ_DISCARD && status.empty |=> status.error)
    else $error("discard on empty queue did not set the error");

endmodule

// ===== src/rdq_datapath.sv =====
// Datapath: ring store, pointers, count, flags and the result register.
module rdq_datapath #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rdq_pkg::cmd_t         cmd,
  input  logic [31:0]           in_value,
  output rdq_pkg::dp_status_t   status,
  output logic [31:0]           out_item_value,
  output rdq_pkg::status_e_t    out_status,
  output logic                  out_last
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  rev_r, rev_nxt;
  logic                  err_r, err_nxt;
  rdq_pkg::status_e_t    res_status_r, res_status_nxt;
  logic                  res_last_r, res_last_nxt;
  logic [VALUE_BITS-1:0] rd_data_r;

  logic                  empty;
  logic                  full;
  logic                  wr_en;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  logic [PTR_W-1:0]      head_inc;
  logic [PTR_W-1:0]      tail_inc;
  logic [PTR_W-1:0]      tail_dec;
  logic [63:0]           in_wide;
  logic [63:0]           rd_wide;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign head_inc = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? PTR_W'(DEPTH - 1) : tail_r - 1'b1;
  assign in_wide  = {32'b0, in_value};
  assign rd_wide  = 64'(rd_data_r);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    rev_nxt        = rev_r;
    err_nxt        = err_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = rev_r ? tail_dec : head_r;
    if (cmd.exec) begin
      case (cmd.req) inside
        rdq_pkg::REQ_PUSH: begin
          if (!full) begin
            wr_en    = 1'b1;
            tail_nxt = tail_inc;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        rdq_pkg::REQ_REVERSE: begin
          if (!err_r) begin
            rev_nxt = ~rev_r;
          end
        end
        rdq_pkg::REQ_DISCARD, rdq_pkg::REQ_TAKE: begin
          if (err_r) begin
            res_status_nxt = rdq_pkg::ST_ERROR;
            res_last_nxt   = empty;
          end else if (empty) begin
            res_status_nxt = rdq_pkg::ST_EMPTY;
            res_last_nxt   = 1'b1;
            if (cmd.req == rdq_pkg::REQ_DISCARD) begin
              err_nxt = 1'b1;
            end
          end else begin
            res_status_nxt = rdq_pkg::ST_OK;
            res_last_nxt   = (cnt_r == CNT_W'(1));
            rd_en          = 1'b1;
            cnt_nxt        = cnt_r - 1'b1;
            if (rev_r) begin
              tail_nxt = tail_dec;
            end else begin
              head_nxt = head_inc;
            end
          end
        end
        rdq_pkg::REQ_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          cnt_nxt  = '0;
          rev_nxt  = 1'b0;
          err_nxt  = 1'b0;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      rev_r        <= 1'b0;
      err_r        <= 1'b0;
      res_status_r <= rdq_pkg::ST_OK;
      res_last_r   <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      rev_r        <= rev_nxt;
      err_r        <= err_nxt;
      res_status_r <= res_status_nxt;
      res_last_r   <= res_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= in_wide[VALUE_BITS-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign status.empty   = empty;
  assign status.error   = err_r;
  assign out_status     = res_status_r;
  assign out_last       = res_last_r;
  assign out_item_value = (res_status_r == rdq_pkg::ST_OK) ? rd_wide[31:0] : 32'b0;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("element count exceeds depth");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && cmd.req == rdq_pkg::REQ_CLEAR |=> cnt_r == '0 && !rev_r && !err_r)
    else $error("clear did not reset the queue state");

endmodule

// ===== src/reversible_deque.sv =====
// Top level of the reversible deque: controller plus datapath.
//
//  channel  | ports                              | item
//  ---------+------------------------------------+--------------------------------
//  in       | in_tvalid in_tready in_tdata/tuser | request kind and push value
//  out      | out_tvalid out_tready out_tdata    | take result with status and last
//           | out_tuser out_tlast                |
//
// Push, reverse, discard and clear give no result. A take shows its result in the
// cycle after acceptance, since the store read is registered, and the result holds
// in its register until taken. Input is stalled while a result waits.
// rst_n clears pointers, count and both flags at once; store contents stay
// undefined until written and are only read where the count covers them.
module reversible_deque #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] item_value
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  rdq_pkg::cmd_t       cmd;
  rdq_pkg::dp_status_t status;
  rdq_pkg::status_e_t  res_status;

  rdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_req     (in_tuser),
    .out_tready (out_tready),
    .status     (status),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  rdq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_tdata),
    .status         (status),
    .out_item_value (out_tdata),
    .out_status     (res_status),
    .out_last       (out_tlast)
  );

  assign out_tuser = res_status;

endmodule
